/* rtl/core/cms_pkg.sv */
// ----------------------------------------------------------------------------
// cms_pkg: shared types and step table for the cassette mechanism sequencer
// Item and result beats, item kinds, step conditions and the fixed
// load/eject step list.
// ----------------------------------------------------------------------------
package cms_pkg;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_EJECT = 2'd2;

  // Step list layout
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 6'd0;
  localparam logic [STEP_W-1:0] LOAD_FIRST  = 6'd1;
  localparam logic [STEP_W-1:0] EJECT_FIRST = 6'd24;
  localparam logic [STEP_W-1:0] STEP_COUNT  = 6'd35;

  localparam int unsigned DELAY_W = 10;
  localparam int unsigned TPM_W   = 16;
  localparam logic [TPM_W-1:0] TPM_RESET = 16'd1;

  // Line bit positions inside the level vector
  localparam int unsigned LVL_PACK_BIT  = 0;
  localparam int unsigned LVL_PAUSE_BIT = 1;
  localparam int unsigned LVL_MODE_BIT  = 2;
  localparam int unsigned LVL_REEL_BIT  = 3;

  localparam logic [3:0] LVL_NONE  = 4'b0000;
  localparam logic [3:0] LVL_PACK  = 4'b0001;
  localparam logic [3:0] LVL_PAUSE = 4'b0010;
  localparam logic [3:0] LVL_MODE  = 4'b0100;
  localparam logic [3:0] LVL_REEL  = 4'b1000;
  // pack 0, pause 0, mode 1, reel 0
  localparam logic [3:0] LVL_RESET = 4'b0100;

  typedef enum logic [2:0] {
    COND_DELAY      = 3'd0,
    COND_FWD_HIGH   = 3'd1,
    COND_REV_HIGH   = 3'd2,
    COND_NOT_BOTH   = 3'd3,
    COND_MOTOR_HIGH = 3'd4,
    COND_MOTOR_LOW  = 3'd5
  } cond_t;

  typedef struct packed {
    cond_t              cond;
    logic [DELAY_W-1:0] ms;
    logic [3:0]         set_mask;
    logic [3:0]         clr_mask;
    logic               last;
  } step_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       forward_in;
    logic       reverse_in;
    logic       motor_on;
  } item_t;

  typedef struct packed {
    logic pack_in_loaded;
    logic pause_playing;
    logic mode_line;
    logic reel_pulse_enable;
    logic busy_res;
    logic tape_running;
  } result_t;

  // Fixed step list: index 0 is idle, load from 1, eject from 24
  function automatic step_t step_entry(input logic [STEP_W-1:0] idx);
    step_t e;
    unique case (idx)
      6'd1:  e = '{COND_FWD_HIGH,   10'd0,   LVL_NONE,  LVL_NONE,  1'b0};
      6'd2:  e = '{COND_DELAY,      10'd900, LVL_PAUSE, LVL_NONE,  1'b0};
      6'd3:  e = '{COND_DELAY,      10'd20,  LVL_NONE,  LVL_MODE,  1'b0};
      6'd4:  e = '{COND_REV_HIGH,   10'd0,   LVL_NONE,  LVL_NONE,  1'b0};
      6'd5:  e = '{COND_NOT_BOTH,   10'd0,   LVL_NONE,  LVL_NONE,  1'b0};
      6'd6:  e = '{COND_REV_HIGH,   10'd0,   LVL_NONE,  LVL_NONE,  1'b0};
      6'd7:  e = '{COND_DELAY,      10'd40,  LVL_MODE,  LVL_NONE,  1'b0};
      6'd8:  e = '{COND_DELAY,      10'd80,  LVL_NONE,  LVL_PAUSE, 1'b0};
      6'd9:  e = '{COND_MOTOR_HIGH, 10'd0,   LVL_REEL,  LVL_NONE,  1'b0};
      6'd10: e = '{COND_MOTOR_LOW,  10'd0,   LVL_NONE,  LVL_REEL,  1'b0};
      6'd11: e = '{COND_MOTOR_HIGH, 10'd0,   LVL_REEL,  LVL_NONE,  1'b0};
      6'd12: e = '{COND_MOTOR_LOW,  10'd0,   LVL_NONE,  LVL_REEL,  1'b0};
      6'd13: e = '{COND_FWD_HIGH,   10'd0,   LVL_NONE,  LVL_NONE,  1'b0};
      6'd14: e = '{COND_DELAY,      10'd20,  LVL_PAUSE, LVL_NONE,  1'b0};
      6'd15: e = '{COND_DELAY,      10'd120, LVL_NONE,  LVL_MODE,  1'b0};
      6'd16: e = '{COND_DELAY,      10'd80,  LVL_MODE,  LVL_NONE,  1'b0};
      6'd17: e = '{COND_DELAY,      10'd80,  LVL_NONE,  LVL_MODE,  1'b0};
      6'd18: e = '{COND_DELAY,      10'd170, LVL_MODE,  LVL_NONE,  1'b0};
      6'd19: e = '{COND_DELAY,      10'd80,  LVL_NONE,  LVL_MODE,  1'b0};
      6'd20: e = '{COND_DELAY,      10'd110, LVL_MODE,  LVL_NONE,  1'b0};
      6'd21: e = '{COND_DELAY,      10'd80,  LVL_NONE,  LVL_MODE,  1'b0};
      6'd22: e = '{COND_DELAY,      10'd90,  LVL_MODE,  LVL_NONE,  1'b0};
      6'd23: e = '{COND_MOTOR_HIGH, 10'd0,   LVL_REEL,  LVL_NONE,  1'b1};
      6'd24: e = '{COND_REV_HIGH,   10'd0,   LVL_NONE,  LVL_NONE,  1'b0};
      6'd25: e = '{COND_DELAY,      10'd90,  LVL_NONE,  LVL_MODE,  1'b0};
      6'd26: e = '{COND_DELAY,      10'd160, LVL_MODE,  LVL_NONE,  1'b0};
      6'd27: e = '{COND_DELAY,      10'd80,  LVL_NONE,  LVL_MODE,  1'b0};
      6'd28: e = '{COND_DELAY,      10'd110, LVL_MODE,  LVL_NONE,  1'b0};
      6'd29: e = '{COND_DELAY,      10'd80,  LVL_NONE,  LVL_MODE,  1'b0};
      6'd30: e = '{COND_DELAY,      10'd170, LVL_MODE,  LVL_NONE,  1'b0};
      6'd31: e = '{COND_DELAY,      10'd80,  LVL_NONE,  LVL_MODE,  1'b0};
      6'd32: e = '{COND_DELAY,      10'd90,  LVL_MODE,  LVL_NONE,  1'b0};
      6'd33: e = '{COND_DELAY,      10'd20,  LVL_NONE,  LVL_PAUSE | LVL_REEL, 1'b0};
      6'd34: e = '{COND_DELAY,      10'd120, LVL_NONE,  LVL_PACK,  1'b1};
      default: e = '{COND_DELAY,    10'd0,   LVL_NONE,  LVL_NONE,  1'b1};
    endcase
    return e;
  endfunction

endpackage

/* rtl/core/cms_engine.sv */
// ----------------------------------------------------------------------------
// cms_engine: step sequencer state and next-state logic
// Holds the step index, delay and prescale counters and the line levels;
// applies one item per beat and presents the levels after that item.
// ----------------------------------------------------------------------------
module cms_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  cms_pkg::item_t             item,
  input  logic [cms_pkg::TPM_W-1:0]  ticks_per_ms,
  output cms_pkg::result_t           result
);

  logic [cms_pkg::STEP_W-1:0]  step_index, step_index_next;
  logic [cms_pkg::DELAY_W-1:0] delay_left, delay_left_next;
  logic [cms_pkg::TPM_W-1:0]   prescale, prescale_next;
  logic [3:0]                  levels, levels_next;
  logic                        running, running_next;

  cms_pkg::step_t              entry;
  cms_pkg::step_t              target_entry;
  logic                        active;
  logic                        done;
  logic                        enter;
  logic [cms_pkg::STEP_W-1:0]  target;
  logic [cms_pkg::STEP_W-1:0]  target_fit;
  logic [cms_pkg::TPM_W-1:0]   tpm_eff;
  logic [cms_pkg::TPM_W-1:0]   prescale_inc;
  logic [cms_pkg::DELAY_W-1:0] delay_dec;

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= cms_pkg::STEP_IDLE;
      delay_left <= '0;
      prescale   <= '0;
      levels     <= cms_pkg::LVL_RESET;
      running    <= 1'b0;
    end else if (fire) begin
      step_index <= step_index_next;
      delay_left <= delay_left_next;
      prescale   <= prescale_next;
      levels     <= levels_next;
      running    <= running_next;
    end
  end

  assign entry        = cms_pkg::step_entry(step_index);
  assign active       = (step_index != cms_pkg::STEP_IDLE) && (step_index < cms_pkg::STEP_COUNT);
  assign tpm_eff      = (ticks_per_ms == '0) ? cms_pkg::TPM_W'(1) : ticks_per_ms;
  assign prescale_inc = prescale + cms_pkg::TPM_W'(1);
  assign delay_dec    = (delay_left != '0) ? delay_left - cms_pkg::DELAY_W'(1) : delay_left;
  assign target_fit   = (target < cms_pkg::STEP_COUNT) ? target : cms_pkg::STEP_IDLE;
  assign target_entry = cms_pkg::step_entry(target_fit);

  // Evaluate the current step and pick the next one
  always_comb begin
    step_index_next = step_index;
    delay_left_next = delay_left;
    prescale_next   = prescale;
    levels_next     = levels;
    running_next    = running;
    done            = 1'b0;
    enter           = 1'b0;
    target          = cms_pkg::STEP_IDLE;

    unique case (item.kind)
      cms_pkg::KIND_TICK: begin
        if (active) begin
          unique case (entry.cond)
            cms_pkg::COND_DELAY: begin
              prescale_next = prescale_inc;
              if (prescale_inc >= tpm_eff) begin
                prescale_next   = '0;
                delay_left_next = delay_dec;
                done            = (delay_dec == '0);
              end
            end
            cms_pkg::COND_FWD_HIGH:   done = item.forward_in;
            cms_pkg::COND_REV_HIGH:   done = item.reverse_in;
            cms_pkg::COND_NOT_BOTH:   done = !(item.forward_in && item.reverse_in);
            cms_pkg::COND_MOTOR_HIGH: done = item.motor_on;
            cms_pkg::COND_MOTOR_LOW:  done = !item.motor_on;
            default:                  done = 1'b0;
          endcase
          if (done) begin
            levels_next = (levels | entry.set_mask) & ~entry.clr_mask;
            enter       = 1'b1;
            target      = entry.last ? cms_pkg::STEP_IDLE
                                     : step_index + cms_pkg::STEP_W'(1);
          end
        end
      end
      cms_pkg::KIND_LOAD: begin
        if (step_index == cms_pkg::STEP_IDLE) begin
          running_next                        = 1'b1;
          levels_next[cms_pkg::LVL_PACK_BIT]  = 1'b1;
          enter                               = 1'b1;
          target                              = cms_pkg::LOAD_FIRST;
        end
      end
      cms_pkg::KIND_EJECT: begin
        if (step_index == cms_pkg::STEP_IDLE) begin
          running_next = 1'b0;
          enter        = 1'b1;
          target       = cms_pkg::EJECT_FIRST;
        end
      end
      default: begin
        enter = 1'b0;
      end
    endcase

    // Start the chosen step with fresh counters
    if (enter) begin
      step_index_next = target_fit;
      prescale_next   = '0;
      delay_left_next = (target_fit != cms_pkg::STEP_IDLE) ? target_entry.ms : '0;
    end
  end

  // Present the levels after this item
  always_comb begin
    result.pack_in_loaded    = levels_next[cms_pkg::LVL_PACK_BIT];
    result.pause_playing     = levels_next[cms_pkg::LVL_PAUSE_BIT];
    result.mode_line         = levels_next[cms_pkg::LVL_MODE_BIT];
    result.reel_pulse_enable = levels_next[cms_pkg::LVL_REEL_BIT];
    result.busy_res          = (step_index_next != cms_pkg::STEP_IDLE);
    result.tape_running      = running_next;
  end

endmodule

/* rtl/core/cassette_mechanism_sequencer.sv */
// ----------------------------------------------------------------------------
// cassette_mechanism_sequencer: cassette mechanism switch-line emulator
// Runs the load and eject sequences for a tape player's mechanism lines.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall / item): one beat per tick with a
//   sample of the forward, reverse and motor lines, or a load or eject
//   command. Commands while a sequence runs are dropped.
//   Result channel (result_valid / result_stall / result): exactly one beat
//   per item, carrying the line levels after that item.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes ticks_per_ms;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   An item is held in an input register, then passes through the step logic
//   into the result register, so both the input and the result register lie
//   between the item beat and result_valid. One item per cycle is sustained
//   while result_stall does not hold a waiting result.
// Reset (rst, synchronous): empties both registers, returns to idle with
//   pack low, pause low, mode high, reel off and ticks_per_ms = 1.
// Stall: while result_stall holds a waiting result, the input register keeps
//   one more item and then item_stall is raised until the result is taken.
// ----------------------------------------------------------------------------
module cassette_mechanism_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  cms_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output cms_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cms_pkg::TPM_W-1:0]  cfg_data
);

  logic                       in_full;
  cms_pkg::item_t             in_item;
  logic [cms_pkg::TPM_W-1:0]  ticks_per_ms;
  cms_pkg::result_t           step_result;
  logic                       advance;
  logic                       accept;

  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= cms_pkg::TPM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_ms <= cfg_data;
    end
  end

  // Capture an item beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= item;
    end
  end

  cms_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .item         (in_item),
    .ticks_per_ms (ticks_per_ms),
    .result       (step_result)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

endmodule

/* rtl/core/cms_checker.sv */
// ----------------------------------------------------------------------------
// cms_checker: port-level checks for the cassette mechanism sequencer
// Watches the result channel for line-level consistency over time.
// ----------------------------------------------------------------------------
module cms_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input cms_pkg::result_t result
);

  // A stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // Every sequence ends with the mode line high
  a_idle_mode_high: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.busy_res |-> result.mode_line)
    else $error("mode line low while idle");

  // Tape running implies a cassette present
  a_running_loaded: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.tape_running |-> result.pack_in_loaded)
    else $error("tape running without pack-in");

endmodule

bind cassette_mechanism_sequencer cms_checker u_cms_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
